@@ hw/rtl/bts_pkg.sv @@
`default_nettype none

package bts_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_LOAD  = 2'd1,
    OP_START = 2'd2,
    OP_STOP  = 2'd3
  } op_t;

  typedef struct packed {
    logic buzz;
    logic playing;
    logic sounding;
  } status_t;

  localparam int unsigned ADDR_W = 10;
  localparam int unsigned BYTE_W = 8;
  localparam logic [BYTE_W-1:0] START_LIMIT = 8'd1;

endpackage

`default_nettype wire

@@ hw/rtl/bts_tune_mem.sv @@
`default_nettype none

module bts_tune_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [AW-1:0]                 waddr,
  input  wire logic [bts_pkg::BYTE_W-1:0]    wdata,
  input  wire logic [AW-1:0]                 raddr0,
  input  wire logic [AW-1:0]                 raddr1,
  output logic      [bts_pkg::BYTE_W-1:0]    rdata0,
  output logic      [bts_pkg::BYTE_W-1:0]    rdata1
);

  logic [bts_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [bts_pkg::BYTE_W-1:0] rd0_r;
  logic [bts_pkg::BYTE_W-1:0] rd1_r;
  logic [AW-1:0]              ra0_r;
  logic [AW-1:0]              ra1_r;
  logic                       wv_r;
  logic [AW-1:0]              wa_r;
  logic [bts_pkg::BYTE_W-1:0] wd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd0_r <= mem[raddr0];
    rd1_r <= mem[raddr1];
    ra0_r <= raddr0;
    ra1_r <= raddr1;
    wv_r  <= we;
    wa_r  <= waddr;
    wd_r  <= wdata;
  end

  // bypass a write that landed in the same cycle as the read
  assign rdata0 = (wv_r && (wa_r == ra0_r)) ? wd_r : rd0_r;
  assign rdata1 = (wv_r && (wa_r == ra1_r)) ? wd_r : rd1_r;

endmodule

`default_nettype wire

@@ hw/rtl/bts_core.sv @@
`default_nettype none

module bts_core #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          accept,
  input  wire logic [1:0]                    op,
  input  wire logic [bts_pkg::ADDR_W-1:0]    addr,
  input  wire logic [bts_pkg::BYTE_W-1:0]    data,
  input  wire logic                          dtick,
  input  wire logic [bts_pkg::BYTE_W-1:0]    rd0,
  input  wire logic [bts_pkg::BYTE_W-1:0]    rd1,
  output logic                               mem_we,
  output logic      [AW-1:0]                 mem_waddr,
  output logic      [bts_pkg::BYTE_W-1:0]    mem_wdata,
  output logic      [AW-1:0]                 mem_raddr0,
  output logic      [AW-1:0]                 mem_raddr1,
  output bts_pkg::status_t                   status_nxt
);

  localparam logic [22:0] DEPTH_W = 23'(DEPTH);

  function automatic logic [AW-1:0] wrap_addr(input logic [bts_pkg::ADDR_W-1:0] a);
    logic [22:0] r;
    r = {13'd0, a};
    for (int k = 5; k >= 0; k--) begin
      if (r >= (DEPTH_W << k)) begin
        r = r - (DEPTH_W << k);
      end
    end
    return r[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] inc_ptr(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  logic [AW-1:0]              ptr_r,     ptr_nxt;
  logic [bts_pkg::BYTE_W-1:0] dcount_r,  dcount_nxt;
  logic [bts_pkg::BYTE_W-1:0] dlimit_r,  dlimit_nxt;
  logic [bts_pkg::BYTE_W-1:0] tperiod_r, tperiod_nxt;
  logic [bts_pkg::BYTE_W-1:0] tcount_r,  tcount_nxt;
  logic                       active_r,  active_nxt;
  logic                       note_r,    note_nxt;
  logic [AW-1:0]              ptr_p1;
  logic [AW-1:0]              addr_w;
  bts_pkg::op_t               op_e;

  assign op_e       = bts_pkg::op_t'(op);
  assign addr_w     = wrap_addr(addr);
  assign ptr_p1     = inc_ptr(ptr_r);
  assign mem_raddr0 = ptr_r;
  assign mem_raddr1 = ptr_p1;
  assign mem_we     = accept && (op_e == bts_pkg::OP_LOAD);
  assign mem_waddr  = addr_w;
  assign mem_wdata  = data;

  always_comb begin
    ptr_nxt     = ptr_r;
    dcount_nxt  = dcount_r;
    dlimit_nxt  = dlimit_r;
    tperiod_nxt = tperiod_r;
    tcount_nxt  = tcount_r;
    active_nxt  = active_r;
    note_nxt    = note_r;
    case (op_e)
      bts_pkg::OP_TICK: begin
        if (active_r) begin
          if (note_r) begin
            tcount_nxt = (tcount_r >= tperiod_r) ? '0 : tcount_r + 1'b1;
          end
          if (dtick) begin
            if (dcount_r >= dlimit_r) begin
              dcount_nxt = '0;
              ptr_nxt    = inc_ptr(ptr_p1);
              if (rd0 == '0) begin
                active_nxt = 1'b0;
                note_nxt   = 1'b0;
              end else begin
                dlimit_nxt = rd0;
                if (rd1 != '0) begin
                  tperiod_nxt = rd1;
                  tcount_nxt  = '0;
                  note_nxt    = 1'b1;
                end else begin
                  note_nxt = 1'b0;
                end
              end
            end else begin
              dcount_nxt = dcount_r + 1'b1;
            end
          end
        end
      end
      bts_pkg::OP_LOAD: begin
      end
      bts_pkg::OP_START: begin
        ptr_nxt    = addr_w;
        dcount_nxt = '0;
        dlimit_nxt = bts_pkg::START_LIMIT;
        active_nxt = 1'b1;
      end
      bts_pkg::OP_STOP: begin
        active_nxt = 1'b0;
        note_nxt   = 1'b0;
      end
      default: begin
      end
    endcase
    status_nxt.buzz     = note_nxt && (tcount_nxt < (tperiod_nxt >> 1));
    status_nxt.playing  = active_nxt;
    status_nxt.sounding = note_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r     <= '0;
      dcount_r  <= '0;
      dlimit_r  <= bts_pkg::START_LIMIT;
      tperiod_r <= '0;
      tcount_r  <= '0;
      active_r  <= 1'b0;
      note_r    <= 1'b0;
    end else if (accept) begin
      ptr_r     <= ptr_nxt;
      dcount_r  <= dcount_nxt;
      dlimit_r  <= dlimit_nxt;
      tperiod_r <= tperiod_nxt;
      tcount_r  <= tcount_nxt;
      active_r  <= active_nxt;
      note_r    <= note_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/buzzer_tune_sequencer.sv @@
`default_nettype none

// Two-pin buzzer melody player. Each request (tick, load byte, start, stop) is taken on its
// handshake and its result appears in the output register on the next cycle; one request
// per cycle is sustained while out_ready stays high. The tune memory is read every cycle at
// the read pointer and the byte after it, so both bytes of a (length, note) pair are ready
// together. Memory contents are undefined after reset until loaded.
module buzzer_tune_sequencer #(
  parameter int unsigned TUNE_BYTES = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_op,
  input  wire logic [bts_pkg::ADDR_W-1:0]    in_addr,
  input  wire logic [bts_pkg::BYTE_W-1:0]    in_data,
  input  wire logic                          in_duration_tick,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_buzzer_one,
  output logic                               out_buzzer_two,
  output logic                               out_playing,
  output logic                               out_sounding
);

  localparam int unsigned AW = $clog2(TUNE_BYTES);

  logic                       accept;
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [bts_pkg::BYTE_W-1:0] mem_wdata;
  logic [AW-1:0]              mem_raddr0;
  logic [AW-1:0]              mem_raddr1;
  logic [bts_pkg::BYTE_W-1:0] rd0;
  logic [bts_pkg::BYTE_W-1:0] rd1;
  bts_pkg::status_t           status_nxt;
  bts_pkg::status_t           status_r;
  logic                       out_valid_r;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  bts_tune_mem #(
    .DEPTH (TUNE_BYTES),
    .AW    (AW)
  ) u_mem (
    .clk    (clk),
    .we     (mem_we),
    .waddr  (mem_waddr),
    .wdata  (mem_wdata),
    .raddr0 (mem_raddr0),
    .raddr1 (mem_raddr1),
    .rdata0 (rd0),
    .rdata1 (rd1)
  );

  bts_core #(
    .DEPTH (TUNE_BYTES),
    .AW    (AW)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .op         (in_op),
    .addr       (in_addr),
    .data       (in_data),
    .dtick      (in_duration_tick),
    .rd0        (rd0),
    .rd1        (rd1),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr0 (mem_raddr0),
    .mem_raddr1 (mem_raddr1),
    .status_nxt (status_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_buzzer_one = status_r.buzz;
  assign out_buzzer_two = status_r.buzz;
  assign out_playing    = status_r.playing;
  assign out_sounding   = status_r.sounding;

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

  localparam int TUNE_BYTES  = 1024;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_GAP     = 60;
  localparam int unsigned ADDR_W = bts_pkg::ADDR_W;
  localparam int unsigned BYTE_W = bts_pkg::BYTE_W;

  typedef struct packed {
    logic buzz_one;
    logic buzz_two;
    logic playing;
    logic sounding;
  } buzzer_status_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        in_op;
  logic [ADDR_W-1:0] in_addr;
  logic [BYTE_W-1:0] in_data;
  logic              in_duration_tick;
  logic              out_valid;
  logic              out_ready;
  logic              out_buzzer_one;
  logic              out_buzzer_two;
  logic              out_playing;
  logic              out_sounding;

  buzzer_tune_sequencer #(
    .TUNE_BYTES(TUNE_BYTES)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_addr          (in_addr),
    .in_data          (in_data),
    .in_duration_tick (in_duration_tick),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_buzzer_one   (out_buzzer_one),
    .out_buzzer_two   (out_buzzer_two),
    .out_playing      (out_playing),
    .out_sounding     (out_sounding)
  );

  // tune player shadow state
  logic [BYTE_W-1:0] tune_mem [0:TUNE_BYTES-1];
  bit                tune_written [0:TUNE_BYTES-1];
  logic [ADDR_W-1:0] rd_ptr = '0;
  logic [BYTE_W-1:0] dur_cnt = '0;
  logic [BYTE_W-1:0] dur_lim = bts_pkg::START_LIMIT;
  logic [BYTE_W-1:0] tone_per = '0;
  logic [BYTE_W-1:0] tone_cnt = '0;
  logic              playing_q = 1'b0;
  logic              sounding_q = 1'b0;

  buzzer_status_t status_q [$];

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int req_cnt      = 0;
  int resp_cnt     = 0;
  int tune_cnt     = 0;
  int fetch_cnt    = 0;
  int errors       = 0;
  int cycle_cnt    = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void fetch_next_note();
    logic [BYTE_W-1:0] len;
    logic [BYTE_W-1:0] note;
    len      = tune_mem[rd_ptr];
    rd_ptr   = rd_ptr + 10'd1;
    note     = tune_mem[rd_ptr];
    rd_ptr   = rd_ptr + 10'd1;
    fetch_cnt++;
    if (len == 8'd0) begin
      playing_q  = 1'b0;
      sounding_q = 1'b0;
    end else begin
      dur_lim = len;
      if (note != 8'd0) begin
        tone_per   = note;
        tone_cnt   = 8'd0;
        sounding_q = 1'b1;
      end else begin
        sounding_q = 1'b0;
      end
    end
  endfunction

  // true unless the next duration tick would fetch from unwritten memory
  function automatic bit next_fetch_defined();
    logic [ADDR_W-1:0] nxt;
    nxt = rd_ptr + 10'd1;
    if (!(playing_q && dur_cnt >= dur_lim)) return 1'b1;
    return tune_written[rd_ptr] && tune_written[nxt];
  endfunction

  function automatic buzzer_status_t predict_status(bts_pkg::op_t op,
                                                    logic [ADDR_W-1:0] addr,
                                                    logic [BYTE_W-1:0] data, logic dtick);
    buzzer_status_t s;
    logic           buzz;
    case (op)
      bts_pkg::OP_TICK: begin
        if (playing_q) begin
          if (sounding_q) tone_cnt = (tone_cnt >= tone_per) ? 8'd0 : tone_cnt + 8'd1;
          if (dtick) begin
            if (dur_cnt >= dur_lim) begin
              dur_cnt = 8'd0;
              fetch_next_note();
            end else begin
              dur_cnt = dur_cnt + 8'd1;
            end
          end
        end
      end
      bts_pkg::OP_LOAD: begin
        tune_mem[addr]     = data;
        tune_written[addr] = 1'b1;
      end
      bts_pkg::OP_START: begin
        rd_ptr    = addr;
        dur_cnt   = 8'd0;
        dur_lim   = bts_pkg::START_LIMIT;
        playing_q = 1'b1;
      end
      default: begin
        playing_q  = 1'b0;
        sounding_q = 1'b0;
      end
    endcase
    buzz       = sounding_q && (tone_cnt < (tone_per >> 1));
    s.buzz_one = buzz;
    s.buzz_two = buzz;
    s.playing  = playing_q;
    s.sounding = sounding_q;
    return s;
  endfunction

  task automatic send_req(input bts_pkg::op_t op, input logic [ADDR_W-1:0] addr,
                          input logic [BYTE_W-1:0] data, input logic dtick);
    int   gap;
    logic dt;
    dt  = dtick;
    gap = 0;
    if (op == bts_pkg::OP_TICK && dt && !next_fetch_defined()) dt = 1'b0;
    if (tx_idle_pct > 0) begin
      while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct) gap++;
    end
    @(negedge clk);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_op            <= op;
    in_addr          <= addr;
    in_data          <= data;
    in_duration_tick <= dt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    status_q.push_back(predict_status(op, addr, data, dt));
    req_cnt++;
  endtask

  function automatic logic [BYTE_W-1:0] pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 80) return BYTE_W'($urandom_range(3, 1));
    if (r < 95) return BYTE_W'($urandom_range(12, 4));
    return BYTE_W'($urandom_range(40, 13));
  endfunction

  function automatic logic [BYTE_W-1:0] pick_note();
    int r;
    r = $urandom_range(99);
    if (r < 15) return 8'd0;
    if (r < 25) return 8'd1;
    if (r < 70) return BYTE_W'($urandom_range(12, 2));
    return BYTE_W'($urandom_range(255, 13));
  endfunction

  // load a short tune at a random base, play it, with a little noise mixed in
  task automatic play_random_tune();
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] a;
    int                npairs;
    int                steps;
    int                r;
    base   = ADDR_W'($urandom_range(TUNE_BYTES - 1));
    npairs = $urandom_range(4, 1);
    a      = base;
    for (int p = 0; p <= npairs; p++) begin
      send_req(bts_pkg::OP_LOAD, a, (p == npairs) ? 8'd0 : pick_length(),
               1'($urandom_range(1)));
      send_req(bts_pkg::OP_LOAD, a + 10'd1, pick_note(), 1'($urandom_range(1)));
      a = a + 10'd2;
    end
    send_req(bts_pkg::OP_START, base, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
    tune_cnt++;
    steps = 0;
    while (playing_q && next_fetch_defined() && steps < 300) begin
      r = $urandom_range(99);
      if (r < 2) begin
        send_req(bts_pkg::OP_STOP, ADDR_W'($urandom_range(1023)),
                 BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
      end else if (r < 4) begin
        send_req(bts_pkg::OP_LOAD, ADDR_W'($urandom_range(1023)),
                 BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
      end else if (r < 5) begin
        send_req(bts_pkg::OP_START, ADDR_W'($urandom_range(1023)),
                 BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
      end else begin
        send_req(bts_pkg::OP_TICK, ADDR_W'($urandom_range(1023)),
                 BYTE_W'($urandom_range(255)), $urandom_range(99) < 70);
      end
      steps++;
    end
    if (playing_q) begin
      send_req(bts_pkg::OP_STOP, ADDR_W'($urandom_range(1023)),
               BYTE_W'($urandom_range(255)), 1'b1);
    end
  endtask

  task automatic run_tune_traffic(input int n_req);
    int stop_at;
    stop_at = req_cnt + n_req;
    while (req_cnt < stop_at) play_random_tune();
  endtask

  task automatic test_directed_playback();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    send_req(bts_pkg::OP_TICK, '0, '0, 1'b1);
    // pair split across the wrap: note one, then rest, then max length and note
    send_req(bts_pkg::OP_LOAD, 10'd1023, 8'd1, 1'b0);
    send_req(bts_pkg::OP_LOAD, 10'd0, 8'd1, 1'b0);
    send_req(bts_pkg::OP_LOAD, 10'd1, 8'd1, 1'b0);
    send_req(bts_pkg::OP_LOAD, 10'd2, 8'd0, 1'b0);
    send_req(bts_pkg::OP_LOAD, 10'd3, 8'd255, 1'b1);
    send_req(bts_pkg::OP_LOAD, 10'd4, 8'd255, 1'b1);
    send_req(bts_pkg::OP_LOAD, 10'd5, 8'd0, 1'b0);
    send_req(bts_pkg::OP_LOAD, 10'd6, 8'd0, 1'b0);
    send_req(bts_pkg::OP_START, 10'd1023, 8'hff, 1'b1);
    repeat (6) send_req(bts_pkg::OP_TICK, 10'h3ff, 8'hff, 1'b1);
    // restart while the long note sounds, then hit the end marker
    send_req(bts_pkg::OP_START, 10'd5, 8'h00, 1'b0);
    repeat (2) send_req(bts_pkg::OP_TICK, 10'h155, 8'h55, 1'b0);
    repeat (2) send_req(bts_pkg::OP_TICK, 10'h2aa, 8'haa, 1'b1);
    send_req(bts_pkg::OP_START, 10'd1, 8'h00, 1'b0);
    repeat (2) send_req(bts_pkg::OP_TICK, 10'h000, 8'h00, 1'b1);
    send_req(bts_pkg::OP_STOP, 10'h3ff, 8'hff, 1'b1);
  endtask

  task automatic test_back_to_back();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    run_tune_traffic(100);
  endtask

  task automatic test_sender_gaps();
    tx_idle_pct  = 88;
    rx_stall_pct = 0;
    run_tune_traffic(100);
  endtask

  task automatic test_receiver_backpressure();
    tx_idle_pct  = 0;
    rx_stall_pct = 88;
    run_tune_traffic(100);
  endtask

  task automatic test_mixed_idle();
    tx_idle_pct  = 15;
    rx_stall_pct = 15;
    run_tune_traffic(100);
  endtask

  always @(negedge clk) begin
    out_ready <= (rx_stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk) begin : check_results
    buzzer_status_t seen;
    buzzer_status_t want;
    if (rst_n && out_valid && out_ready) begin
      seen = {out_buzzer_one, out_buzzer_two, out_playing, out_sounding};
      resp_cnt++;
      if (status_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %b at cycle %0d", seen, cycle_cnt);
      end else begin
        want = status_q.pop_front();
        if (seen.buzz_one !== want.buzz_one || seen.buzz_two !== want.buzz_two ||
            seen.playing !== want.playing || seen.sounding !== want.sounding) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch %0d: buzz %b/%b exp %b/%b playing %b exp %b sounding %b exp %b",
                     resp_cnt, seen.buzz_one, seen.buzz_two, want.buzz_one, want.buzz_two,
                     seen.playing, want.playing, seen.sounding, want.sounding);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, status_q.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_op            = bts_pkg::OP_TICK;
    in_addr          = '0;
    in_data          = '0;
    in_duration_tick = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_playback();
    test_back_to_back();
    test_sender_gaps();
    test_receiver_backpressure();
    test_mixed_idle();

    @(negedge clk);
    in_valid     <= 1'b0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d requests and %0d results over %0d tunes with %0d note fetches",
             req_cnt, resp_cnt, tune_cnt, fetch_cnt);
    $display("idle, sender gap, receiver stall and mixed phases; %0d mismatches", errors);
    if (errors == 0 && status_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
